### sv/ugli_pkg.sv
`default_nettype none

package ugli_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Fixed widths of the item fields and registers.
    localparam int DATA_W  = 32;
    localparam int POS_W   = 32;
    localparam int INDEX_W = 10;
    localparam int CNT_W   = 11;
    localparam int STEP_W  = 32;

    // Product of offset (Q12.20) and reciprocal step (Q16.16) is Q28.36.
    localparam int PROD_W        = POS_W + STEP_W;
    localparam int PROD_FRAC     = 36;
    localparam int IDX_W         = PROD_W - PROD_FRAC;
    localparam int FRACTION_BITS = 16;

    // Blend datapath widths.
    localparam int P0_W  = FRACTION_BITS + 1 + DATA_W;
    localparam int P1_W  = FRACTION_BITS + DATA_W;
    localparam int ACC_W = P0_W + 1;

    // Operation carried in the input tuser.
    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0]
    {
        CFG_SPAN_START   = 2'd0,
        CFG_SPAN_END     = 2'd1,
        CFG_POINT_COUNT  = 2'd2,
        CFG_INVERSE_STEP = 2'd3
    } cfg_index_t;

    // Access request from the pipeline to the sample table.
    typedef struct packed
    {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr0;
        logic [ADDR_W-1:0] raddr1;
    } tbl_req_t;

endpackage

`default_nettype wire

### sv/ugli_table.sv
`default_nettype none

module ugli_table
(
    input  wire logic                            clk,
    input  wire ugli_pkg::tbl_req_t              req,
    output logic     [ugli_pkg::DATA_W-1:0]      rd_data0,
    output logic     [ugli_pkg::DATA_W-1:0]      rd_data1
);

    // Sample storage: one write port and two read ports, read data registered.
    logic [ugli_pkg::DATA_W-1:0] store_reg [ugli_pkg::TABLE_DEPTH];
    logic [ugli_pkg::DATA_W-1:0] rd_data0_reg;
    logic [ugli_pkg::DATA_W-1:0] rd_data1_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            store_reg[req.waddr] <= req.wdata;
        end
    end

    // Read ports; the registered data holds while the pipeline stalls.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data0_reg <= store_reg[req.raddr0];
            rd_data1_reg <= store_reg[req.raddr1];
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

`default_nettype wire

### sv/uniform_grid_linear_interpolator.sv
`default_nettype none

// Linear interpolation over a table of density samples on a uniform grid.
// Input stream (s_*): tuser selects the operation, load or query. A load item
// writes entry_index/entry_value into the table and gives no result. A query
// item gives one result on the output stream (m_*): the blended density in
// tdata and the out-of-range flag in tuser.
// Configuration channel (cfg_*): index 0 span_start, 1 span_end, 2 point_count,
// 3 inverse_step; always ready. The user must write it only while the block is idle; the block does not enforce it.
// A query's result passes through stages A to E and the output register before
// it shows on m_tvalid. Throughput: one item per cycle while the receiver takes
// results, set by the six-stage pipeline and by the table's two read ports serving both neighbor entries at once.
// Table writes and reads happen in the same stage, in item order, so a query
// always sees every load accepted before it.
// Reset clears all stage valid bits and sets the registers to their default
// span; table contents are undefined until loaded.
// When the receiver stalls, the output register holds its item and the stages
// behind it keep filling bubbles; s_tready falls only when every stage is full.
module uniform_grid_linear_interpolator
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,    // entry_index[9:0], entry_value[41:10],
                                         // position[73:42], zero pad [79:74]
    input  wire logic        s_tuser,    // operation

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // density[31:0]
    output logic             m_tuser,    // out_of_range

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int ADDR_W = ugli_pkg::ADDR_W;
    localparam int DATA_W = ugli_pkg::DATA_W;
    localparam int FRAC_W = ugli_pkg::FRACTION_BITS;

    // Configuration registers.
    logic signed [ugli_pkg::POS_W-1:0]  span_start_reg;
    logic signed [ugli_pkg::POS_W-1:0]  span_end_reg;
    logic        [ugli_pkg::CNT_W-1:0]  point_count_reg;
    logic        [ugli_pkg::STEP_W-1:0] inverse_step_reg;

    // Stage A: accepted item.
    logic                                va_reg;
    ugli_pkg::op_t                       op_a_reg;
    logic        [ugli_pkg::INDEX_W-1:0] idx_a_reg;
    logic        [DATA_W-1:0]            val_a_reg;
    logic signed [ugli_pkg::POS_W-1:0]   pos_a_reg;

    // Stage B: range check and offset.
    logic                              vb_reg;
    ugli_pkg::op_t                     op_b_reg;
    logic [ugli_pkg::INDEX_W-1:0]      idx_b_reg;
    logic [DATA_W-1:0]                 val_b_reg;
    logic                              oor_b_reg;
    logic                              end_b_reg;
    logic [ugli_pkg::POS_W-1:0]        off_b_reg;

    // Stage C: grid product.
    logic                              vc_reg;
    ugli_pkg::op_t                     op_c_reg;
    logic [ugli_pkg::INDEX_W-1:0]      idx_c_reg;
    logic [DATA_W-1:0]                 val_c_reg;
    logic                              oor_c_reg;
    logic                              end_c_reg;
    logic [ugli_pkg::PROD_W-1:0]       prod_c_reg;

    // Stage D: table data and weight.
    logic                              vd_reg;
    logic                              oor_d_reg;
    logic [FRAC_W-1:0]                 w_d_reg;

    // Stage E: weighted products.
    logic                              ve_reg;
    logic                              oor_e_reg;
    logic [ugli_pkg::P0_W-1:0]         p0_e_reg;
    logic [ugli_pkg::P1_W-1:0]         p1_e_reg;

    // Output register.
    logic                              vo_reg;
    logic [DATA_W-1:0]                 density_o_reg;
    logic                              oor_o_reg;

    // Stage ready chain: a stage takes new data when empty or moving on.
    logic rdy_o;
    logic rdy_e;
    logic rdy_d;
    logic rdy_c;
    logic rdy_b;
    logic rdy_a;

    assign rdy_o = !vo_reg || m_tready;
    assign rdy_e = !ve_reg || rdy_o;
    assign rdy_d = !vd_reg || rdy_e;
    assign rdy_c = !vc_reg || rdy_d;
    assign rdy_b = !vb_reg || rdy_c;
    assign rdy_a = !va_reg || rdy_b;

    assign s_tready  = rdy_a;
    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_start_reg   <= '0;
            span_end_reg     <= 32'sd1048576;
            point_count_reg  <= ugli_pkg::CNT_W'(2);
            inverse_step_reg <= ugli_pkg::STEP_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ugli_pkg::CFG_SPAN_START:   span_start_reg   <= cfg_data;
                ugli_pkg::CFG_SPAN_END:     span_end_reg     <= cfg_data;
                ugli_pkg::CFG_POINT_COUNT:  point_count_reg  <= cfg_data[ugli_pkg::CNT_W-1:0];
                ugli_pkg::CFG_INVERSE_STEP: inverse_step_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Clamp the point count to the table and find the last entry in use.
    logic [ugli_pkg::CNT_W-1:0] used_points;
    logic [ADDR_W-1:0]          last_idx;

    always_comb
    begin
        if (point_count_reg < ugli_pkg::CNT_W'(2))
        begin
            used_points = ugli_pkg::CNT_W'(2);
        end
        else if (point_count_reg > ugli_pkg::CNT_W'(ugli_pkg::TABLE_DEPTH))
        begin
            used_points = ugli_pkg::CNT_W'(ugli_pkg::TABLE_DEPTH);
        end
        else
        begin
            used_points = point_count_reg;
        end
        last_idx = ADDR_W'(used_points - ugli_pkg::CNT_W'(1));
    end

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= s_tvalid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
            if (rdy_c)
            begin
                vc_reg <= vb_reg;
            end
            // Loads end at stage C once their table write is done.
            if (rdy_d)
            begin
                vd_reg <= vc_reg && (op_c_reg == ugli_pkg::OP_QUERY);
            end
            if (rdy_e)
            begin
                ve_reg <= vd_reg;
            end
            if (rdy_o)
            begin
                vo_reg <= ve_reg;
            end
        end
    end

    // Stage A: unpack the input item.
    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            op_a_reg  <= ugli_pkg::op_t'(s_tuser);
            idx_a_reg <= s_tdata[9:0];
            val_a_reg <= s_tdata[41:10];
            pos_a_reg <= s_tdata[73:42];
        end
    end

    // Stage B: signed range compare and offset from the span start.
    always_ff @(posedge clk)
    begin
        if (rdy_b)
        begin
            op_b_reg  <= op_a_reg;
            idx_b_reg <= idx_a_reg;
            val_b_reg <= val_a_reg;
            oor_b_reg <= (pos_a_reg < span_start_reg) || (pos_a_reg > span_end_reg);
            end_b_reg <= (pos_a_reg == span_end_reg);
            off_b_reg <= pos_a_reg - span_start_reg;
        end
    end

    // Stage C: fractional grid index as offset times reciprocal step.
    logic [ugli_pkg::PROD_W-1:0] prod_next;

    assign prod_next = ugli_pkg::PROD_W'(off_b_reg) * ugli_pkg::PROD_W'(inverse_step_reg);

    always_ff @(posedge clk)
    begin
        if (rdy_c)
        begin
            op_c_reg   <= op_b_reg;
            idx_c_reg  <= idx_b_reg;
            val_c_reg  <= val_b_reg;
            oor_c_reg  <= oor_b_reg;
            end_c_reg  <= end_b_reg;
            prod_c_reg <= prod_next;
        end
    end

    // Stage C to D: table access. A position at the upper end or past the last
    // grid interval reads the last entry with zero weight.
    logic [ugli_pkg::IDX_W-1:0] grid_idx;
    logic [FRAC_W-1:0]          grid_w;
    logic                       sel_last;
    logic [ADDR_W-1:0]          addr_lo;
    logic                       is_load_c;
    logic [FRAC_W-1:0]          w_d_next;
    ugli_pkg::tbl_req_t         tbl_req;
    logic [DATA_W-1:0]          rd_data0;
    logic [DATA_W-1:0]          rd_data1;

    assign grid_idx  = prod_c_reg[ugli_pkg::PROD_W-1:ugli_pkg::PROD_FRAC];
    assign grid_w    = prod_c_reg[ugli_pkg::PROD_FRAC-1 -: FRAC_W];
    assign sel_last  = end_c_reg || (grid_idx >= ugli_pkg::IDX_W'(last_idx));
    assign addr_lo   = grid_idx[ADDR_W-1:0];
    assign is_load_c = vc_reg && (op_c_reg == ugli_pkg::OP_LOAD);
    assign w_d_next  = (sel_last || oor_c_reg) ? '0 : grid_w;

    always_comb
    begin
        tbl_req.we    = is_load_c && rdy_d
                        && (32'(idx_c_reg) < 32'(ugli_pkg::TABLE_DEPTH));
        tbl_req.waddr = ADDR_W'(idx_c_reg);
        tbl_req.wdata = val_c_reg;
        tbl_req.re    = rdy_d;
        if (sel_last)
        begin
            tbl_req.raddr0 = last_idx;
            tbl_req.raddr1 = last_idx;
        end
        else
        begin
            tbl_req.raddr0 = addr_lo;
            tbl_req.raddr1 = addr_lo + ADDR_W'(1);
        end
    end

    ugli_table u_table
    (
        .clk      (clk),
        .req      (tbl_req),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    always_ff @(posedge clk)
    begin
        if (rdy_d)
        begin
            oor_d_reg <= oor_c_reg;
            w_d_reg   <= w_d_next;
        end
    end

    // Stage E: weight both neighbors.
    logic [FRAC_W:0]               w_lo;
    logic [ugli_pkg::P0_W-1:0]     p0_next;
    logic [ugli_pkg::P1_W-1:0]     p1_next;

    assign w_lo    = {1'b1, {FRAC_W{1'b0}}} - {1'b0, w_d_reg};
    assign p0_next = ugli_pkg::P0_W'(w_lo) * ugli_pkg::P0_W'(rd_data0);
    assign p1_next = ugli_pkg::P1_W'(w_d_reg) * ugli_pkg::P1_W'(rd_data1);

    always_ff @(posedge clk)
    begin
        if (rdy_e)
        begin
            oor_e_reg <= oor_d_reg;
            p0_e_reg  <= p0_next;
            p1_e_reg  <= p1_next;
        end
    end

    // Output stage: sum, drop the fraction, force zero outside the span.
    logic [ugli_pkg::ACC_W-1:0] acc_sum;

    assign acc_sum = ugli_pkg::ACC_W'(p0_e_reg) + ugli_pkg::ACC_W'(p1_e_reg);

    always_ff @(posedge clk)
    begin
        if (rdy_o)
        begin
            oor_o_reg     <= oor_e_reg;
            density_o_reg <= oor_e_reg ? '0 : acc_sum[FRAC_W +: DATA_W];
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = density_o_reg;
    assign m_tuser  = oor_o_reg;

`ifndef SYNTHESIS
    // An accepted item always lands in stage A.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> va_reg)
        else $error("accepted item missing from stage A");

    // A load writing the table never turns into a result.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_req.we |=> !vd_reg)
        else $error("load item entered the blend stages");

    // The last-entry case reads with zero weight.
    a_last_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (vc_reg && rdy_d && (op_c_reg == ugli_pkg::OP_QUERY) && sel_last)
        |=> (w_d_reg == '0))
        else $error("last-entry read with nonzero weight");

    // An interpolating read stays below the last entry in use.
    a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vc_reg && (op_c_reg == ugli_pkg::OP_QUERY) && !sel_last)
        |-> (addr_lo < last_idx))
        else $error("neighbor pair read beyond the last entry");
`endif

endmodule

`default_nettype wire

### tb/sv/interpolation_checker.sv
`default_nettype none

// Watches the item, result and register channels of the interpolator, keeps
// its own copy of the sample table and the span registers, works out the
// density of every accepted query and compares it with the results in order.
module interpolation_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,    // entry_index[9:0], entry_value[41:10],
                                         // position[73:42], zero pad [79:74]
    input  wire logic        s_tuser,    // operation

    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,    // density[31:0]
    input  wire logic        m_tuser,    // out_of_range

    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    output int               mismatches,
    output int               outstanding,
    output int               results_checked
);

    import ugli_pkg::*;

    typedef struct packed
    {
        logic [DATA_W-1:0] density;
        logic              out_of_range;
    } interp_result_t;

    // Mirror of the span registers and of the sample table.
    logic signed [POS_W-1:0] span_start;
    logic signed [POS_W-1:0] span_end;
    logic [CNT_W-1:0]        point_count;
    logic [STEP_W-1:0]       inverse_step;
    logic [DATA_W-1:0]       sample_table [TABLE_DEPTH];

    // Densities owed by queries that were accepted but not yet answered.
    interp_result_t expected_densities [$];
    interp_result_t oldest;

    int mismatch_count = 0;
    int result_count   = 0;
    int pending_count  = 0;

    assign mismatches      = mismatch_count;
    assign outstanding     = pending_count;
    assign results_checked = result_count;

    // Prints one line per disagreement and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s: got 0x%h, expected 0x%h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Density of a query under the present span, point count and step.
    function automatic interp_result_t interpolate(input logic signed [POS_W-1:0] pos);
        interp_result_t    r;
        longint            p;
        longint            lo;
        longint            hi;
        longint unsigned   last;
        longint unsigned   offset;
        longint unsigned   product;
        longint unsigned   grid;
        longint unsigned   weight;
        longint unsigned   blend;
        p  = pos;
        lo = span_start;
        hi = span_end;
        r.density      = '0;
        r.out_of_range = 1'b0;
        // A point count outside the table is pulled back to its nearest legal value.
        if (point_count < 2)
            last = 1;
        else if (point_count > TABLE_DEPTH)
            last = TABLE_DEPTH - 1;
        else
            last = point_count - 1;
        if (p < lo || p > hi)
        begin
            r.out_of_range = 1'b1;
        end
        else if (p == hi)
        begin
            // The upper end always returns the last entry in use.
            r.density = sample_table[last];
        end
        else
        begin
            offset  = longint'(p - lo);
            product = offset * longint'(inverse_step);
            grid    = product >> PROD_FRAC;
            if (grid >= last)
            begin
                r.density = sample_table[last];
            end
            else
            begin
                weight = (product >> (PROD_FRAC - FRACTION_BITS))
                       & ((64'd1 << FRACTION_BITS) - 1);
                blend  = ((64'd1 << FRACTION_BITS) - weight) * sample_table[grid]
                       + weight * sample_table[grid + 1];
                r.density = 32'(blend >> FRACTION_BITS);
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_start   = 32'sd0;
            span_end     = 32'sd1048576;
            point_count  = 11'd2;
            inverse_step = 32'd65536;
        end
        else
        begin
            // Results are matched against the oldest query still waiting.
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (expected_densities.size() == 0)
                begin
                    report_mismatch("result with no query waiting", m_tdata, 32'd0);
                end
                else
                begin
                    oldest = expected_densities.pop_front();
                    if (m_tdata !== oldest.density)
                        report_mismatch("density", m_tdata, oldest.density);
                    if (m_tuser !== oldest.out_of_range)
                        report_mismatch("out_of_range", 32'(m_tuser),
                                        32'(oldest.out_of_range));
                end
            end

            // Loads update the table copy; queries queue their density.
            if (s_tvalid && s_tready)
            begin
                if (op_t'(s_tuser) == OP_LOAD)
                    sample_table[s_tdata[INDEX_W-1:0]] = s_tdata[INDEX_W +: DATA_W];
                else
                    expected_densities.push_back(
                        interpolate(s_tdata[INDEX_W + DATA_W +: POS_W]));
            end

            // Register writes.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SPAN_START:   span_start   = cfg_data;
                    CFG_SPAN_END:     span_end     = cfg_data;
                    CFG_POINT_COUNT:  point_count  = cfg_data[CNT_W-1:0];
                    CFG_INVERSE_STEP: inverse_step = cfg_data;
                    default:          ;
                endcase
            end

            pending_count = expected_densities.size();
        end
    end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;

    import ugli_pkg::*;

    localparam int RANDOM_PER_PHASE = 27;
    localparam int DRAIN_CYCLES     = 16;
    localparam int CYCLE_LIMIT      = 500000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_SPAN_START;
    logic [31:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int results_checked;

    int cycle_count   = 0;
    int load_count    = 0;
    int query_count   = 0;
    int setting_count = 0;

    // Gap-free stretches on either side come and go at random.
    bit sender_burst   = 1'b0;
    bit receiver_burst = 1'b0;

    // Span in force, used to aim the query positions.
    longint cur_start = 0;
    longint cur_stop  = 1048576;
    int     cur_count = 2;

    uniform_grid_linear_interpolator uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    interpolation_checker checker_inst
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always #4 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results owed", cycle_count, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: a random wait before taking each result.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = receiver_burst ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if ($urandom_range(0, 39) == 0)
                receiver_burst = !receiver_burst;
        end
    end

    // Sends one item after a random gap and holds it until it is taken.
    task automatic send_item(input op_t op, input logic [9:0] index,
                             input logic [31:0] value, input logic [31:0] pos);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, pos, value, index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_LOAD)
            load_count++;
        else
            query_count++;
        if ($urandom_range(0, 39) == 0)
            sender_burst = !sender_burst;
    endtask

    task automatic load_entry(input logic [9:0] index, input logic [31:0] value);
        send_item(OP_LOAD, index, value, $urandom);
    endtask

    task automatic query_at(input logic [31:0] pos);
        send_item(OP_QUERY, 10'($urandom), $urandom, pos);
    endtask

    // Stops sending, waits for every owed result and lets the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Rewrites all four registers once the block has gone quiet.
    task automatic configure(input longint start, input longint stop,
                             input logic [10:0] count, input logic [31:0] step);
        settle();
        write_reg(CFG_SPAN_START, 32'(start));
        write_reg(CFG_SPAN_END, 32'(stop));
        write_reg(CFG_POINT_COUNT, 32'(count));
        write_reg(CFG_INVERSE_STEP, step);
        cfg_valid <= 1'b0;
        cur_start = start;
        cur_stop  = stop;
        cur_count = count;
        setting_count++;
    endtask

    // Grid points per unit position in Q16.16, truncated or rounded up.
    function automatic logic [31:0] reciprocal_step(input longint width, input int count,
                                                    input bit round_up);
        longint unsigned numer;
        longint unsigned quot;
        if (width <= 0)
            return $urandom;
        numer = longint'(count - 1) << 36;
        quot  = numer / width;
        if (round_up && (numer % width) != 0)
            quot++;
        if (quot > 64'h0000_0000_FFFF_FFFF)
            quot = 64'h0000_0000_FFFF_FFFF;
        return quot[31:0];
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Query positions: span ends and their neighbors, grid points, the inside
    // of the span, and now and then anything at all.
    function automatic logic [31:0] pick_position();
        longint          width;
        longint unsigned offset;
        int              n;
        int              k;
        int              jitter;
        int              mode;
        logic [31:0]     pos;
        width = cur_stop - cur_start;
        n     = (cur_count < 2) ? 2 : ((cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count);
        mode  = $urandom_range(0, 15);
        if (width < 0 && mode > 5)
            mode = 4;
        case (mode)
            0:       pos = 32'(cur_start);
            1:       pos = 32'(cur_stop);
            2:       pos = 32'(cur_start - 1);
            3:       pos = 32'(cur_stop + 1);
            4, 5:    pos = $urandom;
            6:
            begin
                k      = $urandom_range(0, n - 1);
                jitter = int'($urandom_range(0, 2)) - 1;
                pos    = 32'(cur_start + (width * k) / (n - 1) + jitter);
            end
            7:
            begin
                jitter = int'($urandom_range(0, 3));
                pos    = 32'(cur_stop - jitter);
            end
            default:
            begin
                offset = {$urandom, $urandom} % (longint'(width) + 1);
                pos    = 32'(cur_start + longint'(offset));
            end
        endcase
        return pos;
    endfunction

    // One register setting followed by a random mix of loads and queries.
    task automatic run_phase(input longint start, input longint stop,
                             input logic [10:0] count, input logic [31:0] step);
        configure(start, stop, count, step);
        repeat (RANDOM_PER_PHASE)
        begin
            if ($urandom_range(0, 4) == 0)
                load_entry(10'($urandom_range(0, TABLE_DEPTH - 1)), pick_value());
            else
                query_at(pick_position());
        end
    endtask

    task automatic random_phase();
        longint lo;
        longint width;
        int     bits;
        int     pts;
        bit     up;
        lo    = longint'($signed($urandom));
        bits  = $urandom_range(0, 32);
        width = longint'({$urandom, $urandom} & ((64'd1 << bits) - 1));
        if (lo + width > 64'sd2147483647)
            lo = 64'sd2147483647 - width;
        pts = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 16) : $urandom_range(2, 1024);
        up  = $urandom_range(0, 1);
        run_phase(lo, lo + width, 11'(pts), reciprocal_step(width, pts, up));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole table so that no query ever reads an unwritten entry.
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_entry(10'(i), pick_value());

        // Reset span of [0, 1.0] with two points: ends, outside, extremes, blends.
        query_at(32'h0000_0000);
        query_at(32'h0010_0000);
        query_at(32'hFFFF_FFFF);
        query_at(32'h0010_0001);
        query_at(32'h8000_0000);
        query_at(32'h7FFF_FFFF);
        query_at(32'h0008_0000);
        query_at(32'h0000_0001);
        query_at(32'h000F_FFFF);
        load_entry(10'd0, 32'hFFFF_FFFF);
        load_entry(10'd1, 32'hFFFF_FFFF);
        query_at(32'h000C_0000);
        load_entry(10'd1, 32'h0000_0000);
        query_at(32'h0004_0000);
        load_entry(10'd1023, 32'hFFFF_FFFF);
        load_entry(10'd0, 32'h0000_0000);
        query_at(32'h000A_AE60);

        // Widest span with a full table.
        run_phase(-64'sd2147483648, 64'sd2147483647, 11'd1024,
                  reciprocal_step(64'sd4294967295, 1024, 1'b0));
        // Empty span: only its single point is inside.
        run_phase(64'sd3145728, 64'sd3145728, 11'd5, 32'h0001_0000);
        // Reversed span: everything is out of range.
        run_phase(64'sd1048576, -64'sd1048576, 11'd8, 32'h0003_8000);
        // Point counts below two and above the table act as their limits.
        run_phase(64'sd0, 64'sd2097152, 11'd0, 32'h0000_8000);
        run_phase(-64'sd524288, 64'sd524288, 11'd1, 32'h0001_0000);
        run_phase(-64'sd1048576, 64'sd1048576, 11'd2047,
                  reciprocal_step(64'sd2097152, 1024, 1'b0));
        // Zero step lands on the first entry everywhere inside the span but at its upper end.
        run_phase(64'sd1000, 64'sd5000000, 11'd16, 32'd0);
        // Largest step pushes the index past the end.
        run_phase(64'sd0, 64'sd4194304, 11'd10, 32'hFFFF_FFFF);
        // Step rounded up, so the top of the span overruns the last point.
        run_phase(-64'sd3145728, 64'sd2621440, 11'd7,
                  reciprocal_step(64'sd5767168, 7, 1'b1));
        repeat (6)
            random_phase();

        settle();
        $display("Covered %0d table loads and %0d queries over %0d register settings,",
                 load_count, query_count, setting_count);
        $display("with %0d results compared and %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

### uniform_grid_linear_interpolator.f
sv/ugli_pkg.sv
sv/ugli_table.sv
sv/uniform_grid_linear_interpolator.sv
tb/sv/interpolation_checker.sv
tb/sv/testbench.sv
